### design/cttp_pkg.sv
// Shared widths, constants and the front-end hand-off word for the circumcircle core.
package cttp_pkg;

   // Coordinate width and the derived datapath widths
   localparam int CW   = 32;
   localparam int DW   = CW + 1;          // point difference
   localparam int PW   = 2 * DW;          // product of two differences
   localparam int DETW = PW + 1;          // signed determinant
   localparam int DMW  = PW;              // determinant magnitude
   localparam int SW   = PW;              // squared length
   localparam int PPW  = 2 * DW + 1;      // partial product, difference by half a length
   localparam int NW   = DW + SW + 1;     // signed numerator
   localparam int TW   = NW - 1;          // one numerator term
   localparam int NMW  = NW - 1;          // numerator magnitude
   localparam int NUMW = NMW + 2;         // rounded dividend
   localparam int DENW = DMW + 2;         // divisor, four times |det|
   localparam int QB   = CW + 2;          // quotient bits kept before overflow
   localparam int XW   = DENW + QB;       // divider compare width
   localparam int SXW  = QB + 2;          // centre sum width
   localparam int RMW  = CW + 1;          // clamped offset magnitude
   localparam int SQW  = 2 * RMW + 1;     // sum of squared offsets
   localparam int RB   = CW + 1;          // square root bits
   localparam int TRW  = SQW + 1;         // square root trial width

   localparam logic [31:0] THR_RESET = 32'd42950;

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   // Word handed from the front end to the dividers
   typedef struct packed {
      logic                   valid;
      logic                   degen;
      logic                   negx;
      logic                   negy;
      logic [NUMW-1:0]        numx;
      logic [NUMW-1:0]        numy;
      logic [DENW-1:0]        den;
      logic signed [CW-1:0]   x1;
      logic signed [CW-1:0]   y1;
   } front_out_type;

endpackage

### design/cttp_front.sv
// Front end: differences, products, determinant, numerators and divider operands.
module cttp_front import cttp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] x1,
   input  logic signed [CW-1:0] y1,
   input  logic signed [CW-1:0] x2,
   input  logic signed [CW-1:0] y2,
   input  logic signed [CW-1:0] x3,
   input  logic signed [CW-1:0] y3,
   input  logic [31:0]          threshold,
   output front_out_type        fo
);

   typedef logic signed [DW-1:0] diff_type;

   typedef struct packed {
      diff_type             ux;
      diff_type             uy;
      diff_type             vx;
      diff_type             vy;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
   } base_type;

   typedef struct packed {
      logic                 degen;
      logic                 det_neg;
      logic [DMW-1:0]       det_abs;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
   } mid_type;

   logic [6:0] v_ff;

   base_type b1_ff, b2_ff, b3_ff, b1_in;
   logic signed [PW-1:0] uxvy_ff, uyvx_ff, uxux_ff, uyuy_ff, vxvx_ff, vyvy_ff;
   logic signed [DETW-1:0] det_ff;
   logic [SW-1:0] su_ff, sv_ff;
   logic signed [PPW-1:0] pa_lo_ff, pa_hi_ff, pb_lo_ff, pb_hi_ff;
   logic signed [PPW-1:0] pc_lo_ff, pc_hi_ff, pd_lo_ff, pd_hi_ff;
   mid_type m4_ff, m5_ff, m6_ff, m4_in;
   logic signed [TW-1:0] ta_ff, tb_ff, tc_ff, td_ff;
   logic signed [NW-1:0] nx_ff, ny_ff;
   logic [NMW-1:0] nx_abs, ny_abs;
   front_out_type fo_ff;

   // Valid bits travel alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   // Stage 1: offsets of the second and third points from the first
   always_comb begin
      b1_in.ux = {x2[CW-1], x2} - {x1[CW-1], x1};
      b1_in.uy = {y2[CW-1], y2} - {y1[CW-1], y1};
      b1_in.vx = {x3[CW-1], x3} - {x1[CW-1], x1};
      b1_in.vy = {y3[CW-1], y3} - {y1[CW-1], y1};
      b1_in.x1 = x1;
      b1_in.y1 = y1;
   end

   always_ff @(posedge clock) begin
      b1_ff <= b1_in;
   end

   // Stage 2: cross and square products
   always_ff @(posedge clock) begin
      b2_ff   <= b1_ff;
      uxvy_ff <= b1_ff.ux * b1_ff.vy;
      uyvx_ff <= b1_ff.uy * b1_ff.vx;
      uxux_ff <= b1_ff.ux * b1_ff.ux;
      uyuy_ff <= b1_ff.uy * b1_ff.uy;
      vxvx_ff <= b1_ff.vx * b1_ff.vx;
      vyvy_ff <= b1_ff.vy * b1_ff.vy;
   end

   // Stage 3: determinant and squared lengths
   always_ff @(posedge clock) begin
      b3_ff  <= b2_ff;
      det_ff <= DETW'(uxvy_ff) - DETW'(uyvx_ff);
      su_ff  <= SW'(uxux_ff) + SW'(uyuy_ff);
      sv_ff  <= SW'(vxvx_ff) + SW'(vyvy_ff);
   end

   // Stage 4: collinear test and partial products of the numerators
   always_comb begin
      m4_in.det_neg = det_ff[DETW-1];
      m4_in.det_abs = det_ff[DETW-1] ? DMW'(-det_ff) : DMW'(det_ff);
      m4_in.degen   = (m4_in.det_abs == '0) || (m4_in.det_abs < DMW'(threshold));
      m4_in.x1      = b3_ff.x1;
      m4_in.y1      = b3_ff.y1;
   end

   always_ff @(posedge clock) begin
      m4_ff    <= m4_in;
      pa_lo_ff <= b3_ff.vy * signed'({1'b0, su_ff[DW-1:0]});
      pa_hi_ff <= b3_ff.vy * signed'({1'b0, su_ff[SW-1:DW]});
      pb_lo_ff <= b3_ff.uy * signed'({1'b0, sv_ff[DW-1:0]});
      pb_hi_ff <= b3_ff.uy * signed'({1'b0, sv_ff[SW-1:DW]});
      pc_lo_ff <= b3_ff.ux * signed'({1'b0, sv_ff[DW-1:0]});
      pc_hi_ff <= b3_ff.ux * signed'({1'b0, sv_ff[SW-1:DW]});
      pd_lo_ff <= b3_ff.vx * signed'({1'b0, su_ff[DW-1:0]});
      pd_hi_ff <= b3_ff.vx * signed'({1'b0, su_ff[SW-1:DW]});
   end

   // Stage 5: join the partial products
   always_ff @(posedge clock) begin
      m5_ff <= m4_ff;
      ta_ff <= (TW'(pa_hi_ff) <<< DW) + TW'(pa_lo_ff);
      tb_ff <= (TW'(pb_hi_ff) <<< DW) + TW'(pb_lo_ff);
      tc_ff <= (TW'(pc_hi_ff) <<< DW) + TW'(pc_lo_ff);
      td_ff <= (TW'(pd_hi_ff) <<< DW) + TW'(pd_lo_ff);
   end

   // Stage 6: numerators of the two offsets
   always_ff @(posedge clock) begin
      m6_ff <= m5_ff;
      nx_ff <= NW'(ta_ff) - NW'(tb_ff);
      ny_ff <= NW'(tc_ff) - NW'(td_ff);
   end

   // Stage 7: operands for round-to-nearest division, 2|n| + |2det| over |4det|
   assign nx_abs = nx_ff[NW-1] ? NMW'(-nx_ff) : NMW'(nx_ff);
   assign ny_abs = ny_ff[NW-1] ? NMW'(-ny_ff) : NMW'(ny_ff);

   always_ff @(posedge clock) begin
      fo_ff.valid <= 1'b0;   // valid comes from the reset chain below
      fo_ff.degen <= m6_ff.degen;
      fo_ff.negx  <= nx_ff[NW-1] ^ m6_ff.det_neg;
      fo_ff.negy  <= ny_ff[NW-1] ^ m6_ff.det_neg;
      fo_ff.numx  <= NUMW'({nx_abs, 1'b0}) + NUMW'({m6_ff.det_abs, 1'b0});
      fo_ff.numy  <= NUMW'({ny_abs, 1'b0}) + NUMW'({m6_ff.det_abs, 1'b0});
      fo_ff.den   <= {m6_ff.det_abs, 2'b00};
      fo_ff.x1    <= m6_ff.x1;
      fo_ff.y1    <= m6_ff.y1;
   end

   always_comb begin
      fo       = fo_ff;
      fo.valid = v_ff[6];
   end

endmodule

### design/cttp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module cttp_div import cttp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [NUMW-1:0] num,
   input  logic [DENW-1:0] den,
   output logic            out_valid,
   output logic [QB-1:0]   quo,
   output logic            ovf
);

   logic            v_ff   [QB+1];
   logic [QB-1:0]   q_ff   [QB+1];
   logic            ovf_ff [QB+1];
   logic [NUMW-1:0] rem_ff [QB];
   logic [DENW-1:0] den_ff [QB];

   // Entry stage: quotient too wide for the kept bits counts as overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= num;
      den_ff[0] <= den;
      q_ff[0]   <= '0;
      ovf_ff[0] <= {1'b0, num} >= {den, {QB{1'b0}}};
   end

   // One quotient bit per stage, most significant first
   for (genvar i = 0; i < QB; i++) begin : g_stage
      localparam int BIT = QB - 1 - i;
      logic [XW-1:0] trial;
      logic          take;

      assign trial = XW'(den_ff[i]) << BIT;
      assign take  = XW'(rem_ff[i]) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         q_ff[i+1]   <= q_ff[i] | (QB'(take) << BIT);
         ovf_ff[i+1] <= ovf_ff[i];
      end

      if (i < QB - 1) begin : g_fwd
         always_ff @(posedge clock) begin
            rem_ff[i+1] <= take ? NUMW'(XW'(rem_ff[i]) - trial) : rem_ff[i];
            den_ff[i+1] <= den_ff[i];
         end
      end
   end

   assign out_valid = v_ff[QB];
   assign quo       = q_ff[QB];
   assign ovf       = ovf_ff[QB];

endmodule

### design/cttp_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per stage, rounded to nearest.
module cttp_sqrt import cttp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  logic [SQW-1:0] radicand,
   output logic           out_valid,
   output logic [RB:0]    root
);

   logic           v_ff    [RB+1];
   logic [SQW-1:0] rem_ff  [RB+1];
   logic [RB-1:0]  root_ff [RB+1];
   logic           vo_ff;
   logic [RB:0]    res_ff;
   logic           up;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= radicand;
      root_ff[0] <= '0;
   end

   // Trial subtract of (2r + 2^b) * 2^b for each root bit b
   for (genvar i = 0; i < RB; i++) begin : g_stage
      localparam int BIT = RB - 1 - i;
      logic [TRW-1:0] trial;
      logic           take;

      assign trial = (TRW'(root_ff[i]) << (BIT + 1)) + (TRW'(1) << (2 * BIT));
      assign take  = TRW'(rem_ff[i]) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i+1]  <= take ? SQW'(TRW'(rem_ff[i]) - trial) : rem_ff[i];
         root_ff[i+1] <= root_ff[i] | (RB'(take) << BIT);
      end
   end

   // Round: remainder above the root means the value lies past r + 1/2
   assign up = rem_ff[RB] > SQW'(root_ff[RB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= v_ff[RB];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= {1'b0, root_ff[RB]} + (RB+1)'(up);
   end

   assign out_valid = vo_ff;
   assign root      = res_ff;

endmodule

### design/circle_through_three_points_core.sv
// Top level of the circle-through-three-points core: control register, glue and output.
//
// Usage
//   Input: a word of three points (signed Q16.16 x and y each) is taken at a
//   rising edge with start high and busy low. busy stays low: the pipeline
//   takes a new word in every cycle.
//   Output: rsp_valid is high for one cycle with the centre, the radius and the
//   degenerate flag. The receiver cannot hold results off and the core never
//   needs it to: nothing inside stalls.
//   Pipeline: 81 register stages lie between the accepted word and rsp_valid:
//   7 in the front end, 35 in the pipelined divider pair (entry plus 34
//   quotient bits), 3 of centre and squaring, 35 in the square root (entry,
//   33 root bits, rounding) and the output register.
//   Throughput: one word per cycle.
//   csr: csr_wdata sets the collinear threshold at an edge with csr_valid and
//   csr_ready high; csr_ready is always high. Write it only while idle.
//   Reset clears every valid bit and loads the threshold default; words in
//   flight are dropped.
module circle_through_three_points_core import cttp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [CW-1:0] req_first_x,
   input  logic signed [CW-1:0] req_first_y,
   input  logic signed [CW-1:0] req_second_x,
   input  logic signed [CW-1:0] req_second_y,
   input  logic signed [CW-1:0] req_third_x,
   input  logic signed [CW-1:0] req_third_y,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [31:0]          csr_wdata,
   output logic                 rsp_valid,
   output logic signed [CW-1:0] rsp_center_x,
   output logic signed [CW-1:0] rsp_center_y,
   output logic [CW-1:0]        rsp_circle_radius,
   output logic                 rsp_degenerate
);

   typedef struct packed {
      logic                 degen;
      logic                 negx;
      logic                 negy;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
   } side_type;

   typedef struct packed {
      logic                 degen;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
   } post_type;

   logic [31:0]   thr_ff;
   front_out_type fo;
   logic          dx_valid, dy_valid;
   logic [QB-1:0] qx, qy;
   logic          ovfx, ovfy;
   side_type      sd_ff [QB+1];
   side_type      sd_in;

   logic           p1_v_ff, p2_v_ff, p3_v_ff;
   post_type       p1_ff, p2_ff, p3_ff;
   logic [RMW-1:0] rmx_ff, rmy_ff;
   logic [PW-1:0]  sqx_ff, sqy_ff;
   logic [SQW-1:0] s_ff;
   post_type       pd_ff [RB+2];
   logic           sq_valid;
   logic [RB:0]    sq_root;

   logic                 rsp_valid_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic [CW-1:0]        rad_ff;
   logic                 degen_ff;

   // Centre coordinate: first point plus rounded offset, saturated
   function automatic logic signed [CW-1:0] centre_sat(
      input logic signed [CW-1:0] base,
      input logic [QB-1:0]        q,
      input logic                 neg,
      input logic                 ovf
   );
      logic signed [SXW-1:0] off;
      logic signed [SXW-1:0] sum;
      off = neg ? -signed'(SXW'(q)) : signed'(SXW'(q));
      sum = SXW'(base) + off;
      if (ovf) return neg ? CMIN : CMAX;
      if (sum > SXW'(CMAX)) return CMAX;
      if (sum < SXW'(CMIN)) return CMIN;
      return CW'(sum);
   endfunction

   // Offset magnitude clamped to 2^CW for the radius
   function automatic logic [RMW-1:0] clamp_mag(input logic [QB-1:0] q, input logic ovf);
      if (ovf || (q[QB-1:CW] != '0)) return {1'b1, {CW{1'b0}}};
      return {1'b0, q[CW-1:0]};
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Collinear threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_wdata;
      end
   end

   cttp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .x1        (req_first_x),
      .y1        (req_first_y),
      .x2        (req_second_x),
      .y2        (req_second_y),
      .x3        (req_third_x),
      .y3        (req_third_y),
      .threshold (thr_ff),
      .fo        (fo)
   );

   cttp_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fo.valid),
      .num       (fo.numx),
      .den       (fo.den),
      .out_valid (dx_valid),
      .quo       (qx),
      .ovf       (ovfx)
   );

   cttp_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fo.valid),
      .num       (fo.numy),
      .den       (fo.den),
      .out_valid (dy_valid),
      .quo       (qy),
      .ovf       (ovfy)
   );

   // Side data delayed to line up with the dividers
   always_comb begin
      sd_in.degen = fo.degen;
      sd_in.negx  = fo.negx;
      sd_in.negy  = fo.negy;
      sd_in.x1    = fo.x1;
      sd_in.y1    = fo.y1;
   end

   always_ff @(posedge clock) begin
      sd_ff[0] <= sd_in;
      for (int k = 1; k <= QB; k++) begin
         sd_ff[k] <= sd_ff[k-1];
      end
   end

   // Post stages: centre, squared offsets, their sum
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= dx_valid && dy_valid;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff.degen <= sd_ff[QB].degen;
      p1_ff.cx    <= centre_sat(sd_ff[QB].x1, qx, sd_ff[QB].negx, ovfx);
      p1_ff.cy    <= centre_sat(sd_ff[QB].y1, qy, sd_ff[QB].negy, ovfy);
      rmx_ff      <= clamp_mag(qx, ovfx);
      rmy_ff      <= clamp_mag(qy, ovfy);
      p2_ff       <= p1_ff;
      sqx_ff      <= rmx_ff * rmx_ff;
      sqy_ff      <= rmy_ff * rmy_ff;
      p3_ff       <= p2_ff;
      s_ff        <= SQW'(sqx_ff) + SQW'(sqy_ff);
   end

   cttp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p3_v_ff),
      .radicand  (s_ff),
      .out_valid (sq_valid),
      .root      (sq_root)
   );

   // Centre and flag delayed to line up with the square root
   always_ff @(posedge clock) begin
      pd_ff[0] <= p3_ff;
      for (int k = 1; k < RB + 2; k++) begin
         pd_ff[k] <= pd_ff[k-1];
      end
   end

   // Output word; collinear points give zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      degen_ff <= pd_ff[RB+1].degen;
      if (pd_ff[RB+1].degen) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         rad_ff <= '0;
      end else begin
         cx_ff  <= pd_ff[RB+1].cx;
         cy_ff  <= pd_ff[RB+1].cy;
         rad_ff <= (sq_root[RB:CW] != '0) ? {CW{1'b1}} : sq_root[CW-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_center_x      = cx_ff;
   assign rsp_center_y      = cy_ff;
   assign rsp_circle_radius = rad_ff;
   assign rsp_degenerate    = degen_ff;

endmodule
